>>> sv/cpst_pkg.sv
// ----------------------------------------------------------------------------
// cpst_pkg
// Shared types, command codes and defaults for the separating-axis test core.
// ----------------------------------------------------------------------------
`default_nettype none

package cpst_pkg;

  // defaults for the store depths
  localparam int DEFAULT_MAX_VERTICES = 16;
  localparam int DEFAULT_MAX_AXES     = 16;

  localparam int COORD_W = 16;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int DOT_W   = PROD_W + 1;

  // input command codes
  localparam logic [2:0] CMD_VTX_A  = 3'd0;
  localparam logic [2:0] CMD_AXIS_A = 3'd1;
  localparam logic [2:0] CMD_VTX_B  = 3'd2;
  localparam logic [2:0] CMD_AXIS_B = 3'd3;
  localparam logic [2:0] CMD_EVAL   = 3'd4;

  typedef struct packed {
    logic [2:0]                cmd;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } cpst_in_t;

  typedef struct packed {
    logic intersects;
    logic load_overflow;
  } cpst_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // store the input item
    logic axis_rd;    // read both axis stores at the axis index
    logic axis_ld;    // latch the selected axis, rewind vertex index
    logic vtx_rd;     // read both vertex stores at the vertex index
    logic mul;        // form the two partial products
    logic acc;        // add and fold into the interval of the current shape
    logic axis_next;  // step the axis index
    logic axis_b;     // axis set select
    logic shape_b;    // vertex set select
    logic out_load;   // capture the result
    logic hit;        // result value to capture
    logic clear;      // empty all stores after evaluate
  } cpst_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic axis_a_empty;
    logic axis_b_empty;
    logic vtx_empty;   // either vertex set empty
    logic axis_last;
    logic vtx_last;
    logic separated;
  } cpst_sts_t;

endpackage

`default_nettype wire

>>> sv/cpst_dp.sv
// ----------------------------------------------------------------------------
// cpst_dp
// Datapath: four stores, counts, one dot-product unit and interval tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module cpst_dp #(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_AXES     = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  cpst_pkg::cpst_in_t  in_data,
  input  cpst_pkg::cpst_cmd_t cmd,
  output cpst_pkg::cpst_sts_t sts,
  output cpst_pkg::cpst_out_t out_data
);
  import cpst_pkg::*;

  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int ACW = $clog2(MAX_AXES + 1);
  localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int AAW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
  localparam int WW  = 2 * COORD_W;

  logic [WW-1:0] vtx_a_mem  [MAX_VERTICES];
  logic [WW-1:0] vtx_b_mem  [MAX_VERTICES];
  logic [WW-1:0] axis_a_mem [MAX_AXES];
  logic [WW-1:0] axis_b_mem [MAX_AXES];

  logic [VCW-1:0] vcnt_a_r, vcnt_b_r;
  logic [ACW-1:0] acnt_a_r, acnt_b_r;
  logic           ovf_r;

  logic [AAW-1:0] axis_idx_r;
  logic [VAW-1:0] vtx_idx_r;

  logic [WW-1:0] axis_a_rd_r, axis_b_rd_r, vtx_a_rd_r, vtx_b_rd_r;
  logic [WW-1:0] axis_r;
  logic signed [PROD_W-1:0] px_r, py_r;
  logic signed [DOT_W-1:0]  lo_a_r, hi_a_r, lo_b_r, hi_b_r;
  cpst_out_t out_r;

  logic [WW-1:0] word;
  logic [WW-1:0] vsel;
  logic signed [DOT_W-1:0] dot;
  logic vfull_a, vfull_b, afull_a, afull_b;
  logic wr_va, wr_vb, wr_aa, wr_ab;
  logic [VCW-1:0] vcnt_sel;
  logic [ACW-1:0] acnt_sel;
  logic vtx_last, axis_last;

  assign word    = {in_data.coord_y, in_data.coord_x};
  assign vfull_a = (vcnt_a_r == VCW'(MAX_VERTICES));
  assign vfull_b = (vcnt_b_r == VCW'(MAX_VERTICES));
  assign afull_a = (acnt_a_r == ACW'(MAX_AXES));
  assign afull_b = (acnt_b_r == ACW'(MAX_AXES));

  assign wr_va = cmd.load && (in_data.cmd == CMD_VTX_A)  && !vfull_a;
  assign wr_vb = cmd.load && (in_data.cmd == CMD_VTX_B)  && !vfull_b;
  assign wr_aa = cmd.load && (in_data.cmd == CMD_AXIS_A) && !afull_a;
  assign wr_ab = cmd.load && (in_data.cmd == CMD_AXIS_B) && !afull_b;

  // counts and overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      vcnt_a_r <= '0;
      vcnt_b_r <= '0;
      acnt_a_r <= '0;
      acnt_b_r <= '0;
      ovf_r    <= 1'b0;
    end else if (cmd.load) begin
      unique case (in_data.cmd)
        CMD_VTX_A: begin
          if (vfull_a) ovf_r <= 1'b1;
          else vcnt_a_r <= vcnt_a_r + VCW'(1);
        end
        CMD_VTX_B: begin
          if (vfull_b) ovf_r <= 1'b1;
          else vcnt_b_r <= vcnt_b_r + VCW'(1);
        end
        CMD_AXIS_A: begin
          if (afull_a) ovf_r <= 1'b1;
          else acnt_a_r <= acnt_a_r + ACW'(1);
        end
        CMD_AXIS_B: begin
          if (afull_b) ovf_r <= 1'b1;
          else acnt_b_r <= acnt_b_r + ACW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // stores, one write and one registered read each
  always_ff @(posedge clk) begin
    if (wr_va) vtx_a_mem[vcnt_a_r[VAW-1:0]] <= word;
    if (wr_vb) vtx_b_mem[vcnt_b_r[VAW-1:0]] <= word;
    if (wr_aa) axis_a_mem[acnt_a_r[AAW-1:0]] <= word;
    if (wr_ab) axis_b_mem[acnt_b_r[AAW-1:0]] <= word;
    if (cmd.axis_rd) begin
      axis_a_rd_r <= axis_a_mem[axis_idx_r];
      axis_b_rd_r <= axis_b_mem[axis_idx_r];
    end
    if (cmd.vtx_rd) begin
      vtx_a_rd_r <= vtx_a_mem[vtx_idx_r];
      vtx_b_rd_r <= vtx_b_mem[vtx_idx_r];
    end
  end

  assign vcnt_sel  = cmd.shape_b ? vcnt_b_r : vcnt_a_r;
  assign acnt_sel  = cmd.axis_b ? acnt_b_r : acnt_a_r;
  assign vtx_last  = ((VCW'(vtx_idx_r) + VCW'(1)) == vcnt_sel);
  assign axis_last = ((ACW'(axis_idx_r) + ACW'(1)) == acnt_sel);

  // walk indexes
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      axis_idx_r <= '0;
      vtx_idx_r  <= '0;
    end else begin
      if (cmd.axis_next) axis_idx_r <= axis_last ? '0 : axis_idx_r + AAW'(1);
      if (cmd.axis_ld) vtx_idx_r <= '0;
      else if (cmd.acc) vtx_idx_r <= vtx_last ? '0 : vtx_idx_r + VAW'(1);
    end
  end

  // projection: products, then sum and interval update
  assign vsel = cmd.shape_b ? vtx_b_rd_r : vtx_a_rd_r;
  assign dot  = DOT_W'(px_r) + DOT_W'(py_r);

  always_ff @(posedge clk) begin
    if (cmd.axis_ld) axis_r <= cmd.axis_b ? axis_b_rd_r : axis_a_rd_r;
    if (cmd.mul) begin
      px_r <= $signed(vsel[COORD_W-1:0]) * $signed(axis_r[COORD_W-1:0]);
      py_r <= $signed(vsel[WW-1:COORD_W]) * $signed(axis_r[WW-1:COORD_W]);
    end
    if (cmd.acc) begin
      if (cmd.shape_b) begin
        if (vtx_idx_r == '0 || dot < lo_b_r) lo_b_r <= dot;
        if (vtx_idx_r == '0 || dot > hi_b_r) hi_b_r <= dot;
      end else begin
        if (vtx_idx_r == '0 || dot < lo_a_r) lo_a_r <= dot;
        if (vtx_idx_r == '0 || dot > hi_a_r) hi_a_r <= dot;
      end
    end
    if (cmd.out_load) begin
      out_r.intersects    <= cmd.hit;
      out_r.load_overflow <= ovf_r;
    end
  end

  assign sts.axis_a_empty = (acnt_a_r == '0);
  assign sts.axis_b_empty = (acnt_b_r == '0);
  assign sts.vtx_empty    = (vcnt_a_r == '0) || (vcnt_b_r == '0);
  assign sts.axis_last    = axis_last;
  assign sts.vtx_last     = vtx_last;
  assign sts.separated    = (hi_a_r < lo_b_r) || (hi_b_r < lo_a_r);

  assign out_data = out_r;

endmodule

`default_nettype wire

>>> sv/cpst_ctrl.sv
// ----------------------------------------------------------------------------
// cpst_ctrl
// Sequencer: takes loads, walks axes and vertices on evaluate, holds result.
// ----------------------------------------------------------------------------
`default_nettype none

module cpst_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [2:0]          in_cmd,
  output logic                out_valid,
  input  wire                 out_ready,
  output cpst_pkg::cpst_cmd_t cmd,
  input  cpst_pkg::cpst_sts_t sts
);
  import cpst_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_AXRD  = 4'd2;
  localparam logic [3:0] S_AXLD  = 4'd3;
  localparam logic [3:0] S_VRD   = 4'd4;
  localparam logic [3:0] S_VMUL  = 4'd5;
  localparam logic [3:0] S_VACC  = 4'd6;
  localparam logic [3:0] S_AXCHK = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       axis_b_r, axis_b_nxt;
  logic       shape_b_r, shape_b_nxt;
  logic       hit_r, hit_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       commit;

  assign in_ready = (state_r == S_IDLE);
  assign commit   = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    axis_b_nxt    = axis_b_r;
    shape_b_nxt   = shape_b_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_cmd == CMD_EVAL) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.axis_a_empty && sts.axis_b_empty) begin
          hit_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (sts.vtx_empty) begin
          hit_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          axis_b_nxt = sts.axis_a_empty;
          state_nxt  = S_AXRD;
        end
      end
      S_AXRD: state_nxt = S_AXLD;
      S_AXLD: begin
        shape_b_nxt = 1'b0;
        state_nxt   = S_VRD;
      end
      S_VRD:  state_nxt = S_VMUL;
      S_VMUL: state_nxt = S_VACC;
      S_VACC: begin
        if (!sts.vtx_last) state_nxt = S_VRD;
        else if (!shape_b_r) begin
          shape_b_nxt = 1'b1;
          state_nxt   = S_VRD;
        end else state_nxt = S_AXCHK;
      end
      S_AXCHK: begin
        if (sts.separated) begin
          hit_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else if (!sts.axis_last) state_nxt = S_AXRD;
        else if (!axis_b_r && !sts.axis_b_empty) begin
          axis_b_nxt = 1'b1;
          state_nxt  = S_AXRD;
        end else begin
          hit_nxt   = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_b_r    <= 1'b0;
      shape_b_r   <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_b_r    <= axis_b_nxt;
      shape_b_r   <= shape_b_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == S_IDLE) && in_valid;
    cmd.axis_rd   = (state_r == S_AXRD);
    cmd.axis_ld   = (state_r == S_AXLD);
    cmd.vtx_rd    = (state_r == S_VRD);
    cmd.mul       = (state_r == S_VMUL);
    cmd.acc       = (state_r == S_VACC);
    cmd.axis_next = (state_r == S_AXCHK);
    cmd.axis_b    = axis_b_r;
    cmd.shape_b   = shape_b_r;
    cmd.out_load  = commit;
    cmd.hit       = hit_r;
    cmd.clear     = commit;
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // only one walk step is issued per cycle
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.axis_rd, cmd.axis_ld, cmd.vtx_rd, cmd.mul, cmd.acc, cmd.axis_next}))
    else $error("more than one walk step at once");

  // no store write while an evaluate is in flight
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !cmd.load)
    else $error("load while evaluating");

  // a pending result is never dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("result dropped before transfer");

  // a commit always leaves a result and an idle sequencer
  a_commit: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (out_valid_r && state_r == S_IDLE))
    else $error("commit did not post a result");
`endif

endmodule

`default_nettype wire

>>> sv/convex_polygon_sat_test_core.sv
// ----------------------------------------------------------------------------
// convex_polygon_sat_test_core
// Separating-axis overlap test for two convex 2D shapes in signed Q8.8.
// ----------------------------------------------------------------------------
//
//  channel  | ports                         | moves
//  ---------+-------------------------------+------------------------------
//  input    | in_valid, in_ready, in_data   | load vertex/normal or evaluate
//  result   | out_valid, out_ready, out_data| intersects, load_overflow
//
//  loads may follow back to back
//  evaluate checks the counts, then per stored normal (stopping early at a
//  separating axis) reads the normal and projects every vertex of A, then B,
//  through the one shared dot-product unit and one read port per store
//  an empty vertex set or no normals at all settles at the count check, no walk
//  rst_n is synchronous: all counts and the overflow flag clear, stores do not
//  in_ready is low during an evaluate and while its result waits for the slot
// ----------------------------------------------------------------------------
`default_nettype none

module convex_polygon_sat_test_core #(
  parameter int MAX_VERTICES = cpst_pkg::DEFAULT_MAX_VERTICES,
  parameter int MAX_AXES     = cpst_pkg::DEFAULT_MAX_AXES
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  cpst_pkg::cpst_in_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output cpst_pkg::cpst_out_t out_data
);
  import cpst_pkg::*;

  cpst_cmd_t cmd;
  cpst_sts_t sts;

  // sequencer: load gating, axis/vertex walk, result slot
  cpst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_data.cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // stores, exact 33-bit projections and interval compare
  cpst_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_AXES     (MAX_AXES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
